// File: src/sos_pkg.sv
`default_nettype none

package sos_pkg;

    localparam int MAX_SUBSTACKS_DEF  = 16;
    localparam int SUBSTACK_DEPTH_DEF = 16;

    localparam int W_VALUE  = 32;
    localparam int W_OPCODE = 2;
    localparam int W_INDEX  = 4;
    localparam int W_STATUS = 2;
    localparam int W_CAP    = 5;
    localparam int W_INUSE  = 5;

    localparam logic [W_CAP-1:0] CAPACITY_RESET = 5'd3;

    typedef enum logic [W_OPCODE-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_POP_AT = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [W_STATUS-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    // outcome of one operation, handed from the slot controller to the top
    typedef struct packed {
        t_status status;
        logic    take;      // a value is read from the plate RAM
    } t_op_info;

endpackage

`default_nettype wire

// File: src/set_of_stacks_engine_core.sv
// Pipeline: an accepted item passes through the plate RAM read register,
//   where its status is held, and then through the output register.
// Flow: a new item is not taken while the last one waits on the RAM read,
//   and a result held off by the consumer stalls the input until it
//   transfers.
// Reset (synchronous, active low): no substacks in use, every fill count
//   zero, slot map identity, capacity 3. The plate RAM is not cleared.
`default_nettype none

module set_of_stacks_engine_core #(
    parameter int MAX_SUBSTACKS  = sos_pkg::MAX_SUBSTACKS_DEF,
    parameter int SUBSTACK_DEPTH = sos_pkg::SUBSTACK_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration: substack capacity
    input  wire logic                               i_cfg_we,
    input  wire logic [sos_pkg::W_CAP-1:0]          i_cfg_data,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [sos_pkg::W_OPCODE-1:0]       i_opcode,
    input  wire logic signed [sos_pkg::W_VALUE-1:0] i_push_value,
    input  wire logic [sos_pkg::W_INDEX-1:0]        i_substack_index,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [sos_pkg::W_VALUE-1:0]      o_popped_value,
    output logic [sos_pkg::W_STATUS-1:0]            o_status,
    output logic [sos_pkg::W_INUSE-1:0]             o_substacks_in_use
);
    import sos_pkg::*;

    localparam int W_ACT  = $clog2(MAX_SUBSTACKS + 1);
    localparam int W_POS  = $clog2(MAX_SUBSTACKS);
    localparam int W_LVL  = (SUBSTACK_DEPTH > 1) ? $clog2(SUBSTACK_DEPTH) : 1;
    localparam int W_ADDR = W_POS + W_LVL;

    logic [W_CAP-1:0]   r_cap;
    logic               r_pend;
    t_status            r_status;
    logic               r_take;
    logic               r_out_valid;
    logic [W_VALUE-1:0] r_popped;
    t_status            r_out_status;
    logic [W_INUSE-1:0] r_out_inuse;

    logic               in_xfer;
    t_op_info           info;
    logic [W_ACT-1:0]   active;
    logic               mem_we;
    logic               mem_re;
    logic [W_ADDR-1:0]  mem_addr;
    logic [W_VALUE-1:0] mem_rdata;

    // Stall while an item waits on the RAM read, or while a finished result
    // sits in the output register and the consumer holds it off.
    assign o_in_stall = r_pend || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Slot map, fill counts and substack count; decides the operation and
    // drives the RAM in the transfer cycle.
    sos_slot_ctrl #(
        .MAX_SUBSTACKS  (MAX_SUBSTACKS),
        .SUBSTACK_DEPTH (SUBSTACK_DEPTH),
        .W_ACT          (W_ACT),
        .W_ADDR         (W_ADDR)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (in_xfer),
        .i_opcode   (t_opcode'(i_opcode)),
        .i_index    (i_substack_index),
        .i_cap      (r_cap),
        .o_info     (info),
        .o_active   (active),
        .o_mem_we   (mem_we),
        .o_mem_re   (mem_re),
        .o_mem_addr (mem_addr)
    );

    // Plate RAM: one word per (slot, level); a push writes, a pop reads the top.
    sos_plate_ram #(
        .W_ADDR (W_ADDR)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (i_push_value),
        .o_rdata (mem_rdata)
    );

    // Hold status for the read cycle, then load the output register once the
    // RAM data is out. The substack count is already updated at that point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= in_xfer;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status <= info.status;
            r_take   <= info.take;
        end
        if (r_pend) begin
            r_popped     <= r_take ? mem_rdata : '0;
            r_out_status <= r_status;
            r_out_inuse  <= W_INUSE'(active);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_popped_value     = r_popped;
    assign o_status           = r_out_status;
    assign o_substacks_in_use = r_out_inuse;

endmodule

`default_nettype wire

// File: src/sos_plate_ram.sv
`default_nettype none

module sos_plate_ram #(
    parameter int W_ADDR = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic                         i_re,
    input  wire logic [W_ADDR-1:0]            i_addr,
    input  wire logic [sos_pkg::W_VALUE-1:0]  i_wdata,
    output logic      [sos_pkg::W_VALUE-1:0]  o_rdata
);
    import sos_pkg::*;

    localparam int WORDS = 1 << W_ADDR;

    logic [W_VALUE-1:0] r_mem [WORDS];
    logic [W_VALUE-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/sos_slot_ctrl.sv
`default_nettype none

module sos_slot_ctrl #(
    parameter int MAX_SUBSTACKS  = sos_pkg::MAX_SUBSTACKS_DEF,
    parameter int SUBSTACK_DEPTH = sos_pkg::SUBSTACK_DEPTH_DEF,
    parameter int W_ACT  = $clog2(MAX_SUBSTACKS + 1),
    parameter int W_ADDR = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_go,
    input  wire sos_pkg::t_opcode             i_opcode,
    input  wire logic [sos_pkg::W_INDEX-1:0]  i_index,
    input  wire logic [sos_pkg::W_CAP-1:0]    i_cap,
    output sos_pkg::t_op_info                 o_info,
    output logic      [W_ACT-1:0]             o_active,
    output logic                              o_mem_we,
    output logic                              o_mem_re,
    output logic      [W_ADDR-1:0]            o_mem_addr
);
    import sos_pkg::*;

    localparam int W_POS  = $clog2(MAX_SUBSTACKS);
    localparam int W_FILL = $clog2(SUBSTACK_DEPTH + 1);
    localparam int W_LVL  = (SUBSTACK_DEPTH > 1) ? $clog2(SUBSTACK_DEPTH) : 1;
    localparam int W_CMP  = (W_FILL > W_CAP) ? W_FILL : W_CAP;
    localparam int W_WIDE = (W_ACT > W_INDEX) ? W_ACT : W_INDEX;

    logic [W_POS-1:0]  r_map  [MAX_SUBSTACKS];
    logic [W_FILL-1:0] r_fill [MAX_SUBSTACKS];
    logic [W_ACT-1:0]  r_active;

    logic [W_POS-1:0]  n_map  [MAX_SUBSTACKS];
    logic [W_FILL-1:0] n_fill [MAX_SUBSTACKS];
    logic [W_ACT-1:0]  n_active;

    logic [W_CMP-1:0]  cap_wide;
    logic [W_CMP-1:0]  cap_eff;
    logic [W_ACT-1:0]  act_m1;
    logic [W_POS-1:0]  last_slot;
    logic [W_POS-1:0]  new_slot;
    logic [W_FILL-1:0] last_fill;
    logic              need_new;
    logic              is_full;
    logic [W_WIDE-1:0] idx_wide;
    logic [W_WIDE-1:0] act_wide;
    logic [W_WIDE-1:0] pos_wide;
    logic [W_POS-1:0]  pos;
    logic [W_POS-1:0]  pop_slot;
    logic [W_FILL-1:0] pop_level;
    logic [W_POS-1:0]  push_slot;
    logic [W_FILL-1:0] push_level;
    logic              do_push;
    logic              do_pop;
    t_status           status;

    // effective capacity: zero acts as one, saturate at the slot depth
    always_comb begin
        cap_wide = W_CMP'(i_cap);
        if (cap_wide == '0) begin
            cap_eff = W_CMP'(1);
        end else if (cap_wide > W_CMP'(SUBSTACK_DEPTH)) begin
            cap_eff = W_CMP'(SUBSTACK_DEPTH);
        end else begin
            cap_eff = cap_wide;
        end
    end

    assign act_m1    = r_active - W_ACT'(1);
    assign last_slot = r_map[act_m1[W_POS-1:0]];
    assign new_slot  = r_map[r_active[W_POS-1:0]];
    assign last_fill = r_fill[last_slot];
    assign need_new  = (r_active == '0) || (W_CMP'(last_fill) >= cap_eff);
    assign is_full   = (r_active == W_ACT'(MAX_SUBSTACKS));

    assign idx_wide  = W_WIDE'(i_index);
    assign act_wide  = W_WIDE'(r_active);
    assign pos_wide  = (i_opcode == OP_POP_AT) ? idx_wide : W_WIDE'(act_m1);
    assign pos       = pos_wide[W_POS-1:0];
    assign pop_slot  = r_map[pos];
    assign pop_level = r_fill[pop_slot] - W_FILL'(1);

    assign push_slot  = need_new ? new_slot : last_slot;
    assign push_level = need_new ? '0 : last_fill;

    always_comb begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        status  = ST_OK;
        case (i_opcode)
            OP_PUSH: begin
                if (need_new && is_full) begin
                    status = ST_OVERFLOW;
                end else begin
                    do_push = 1'b1;
                end
            end
            OP_POP: begin
                if (r_active == '0) begin
                    status = ST_EMPTY;
                end else begin
                    do_pop = 1'b1;
                end
            end
            OP_POP_AT: begin
                if (idx_wide >= act_wide) begin
                    status = ST_BAD_INDEX;
                end else begin
                    do_pop = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // next state of counts and slot map
    always_comb begin
        n_map    = r_map;
        n_fill   = r_fill;
        n_active = r_active;
        if (do_push) begin
            n_fill[push_slot] = push_level + W_FILL'(1);
            if (need_new) begin
                n_active = r_active + W_ACT'(1);
            end
        end else if (do_pop) begin
            n_fill[pop_slot] = pop_level;
            if (pop_level == '0) begin
                // close the gap: later positions shift down, emptied slot goes last
                for (int i = 0; i < MAX_SUBSTACKS - 1; i++) begin
                    if ((i >= int'(pos)) && (i + 1 < int'(r_active))) begin
                        n_map[i] = r_map[i + 1];
                    end
                end
                n_map[act_m1[W_POS-1:0]] = pop_slot;
                n_active = act_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SUBSTACKS; i++) begin
                r_map[i]  <= W_POS'(i);
                r_fill[i] <= '0;
            end
            r_active <= '0;
        end else if (i_go) begin
            r_map    <= n_map;
            r_fill   <= n_fill;
            r_active <= n_active;
        end
    end

    assign o_info.status = status;
    assign o_info.take   = do_pop;
    assign o_active      = r_active;
    assign o_mem_we      = i_go && do_push;
    assign o_mem_re      = i_go && do_pop;
    assign o_mem_addr    = do_push ? {push_slot, push_level[W_LVL-1:0]}
                                   : {pop_slot, pop_level[W_LVL-1:0]};

endmodule

`default_nettype wire

// File: verif/set_of_stacks_engine_core_tb.sv
`timescale 1ns / 1ps

module set_of_stacks_engine_core_tb;
    import sos_pkg::*;

    localparam int SLOTS = MAX_SUBSTACKS_DEF;
    localparam int DEPTH = SUBSTACK_DEPTH_DEF;

    // One result as the output channel presents it.
    typedef struct packed {
        logic signed [W_VALUE-1:0] popped;
        t_status                   status;
        logic [W_INUSE-1:0]        in_use;
    } t_plate_outcome;

    // Tracks the substacks as the block should hold them and keeps the
    // outcomes still owed by the block, oldest first.
    class t_substack_tracker;
        logic [W_VALUE-1:0] plate_mem [SLOTS*DEPTH];
        int                 fill [SLOTS];
        int                 slot_of [SLOTS];
        int                 in_use;
        logic [W_CAP-1:0]   capacity;
        t_plate_outcome     expected_outcomes [$];
        int                 mismatches;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                fill[i]    = 0;
                slot_of[i] = i;
            end
            in_use     = 0;
            capacity   = CAPACITY_RESET;
            mismatches = 0;
        endfunction

        function void write_capacity(logic [W_CAP-1:0] c);
            capacity = c;
        endfunction

        // Remove the top plate of a live substack; close the substack when
        // it runs dry and shift the later positions down.
        function logic [W_VALUE-1:0] take_plate(int pos);
            int slot;
            logic [W_VALUE-1:0] v;
            slot = slot_of[pos];
            fill[slot]--;
            v = plate_mem[slot*DEPTH + fill[slot]];
            if (fill[slot] == 0) begin
                for (int i = pos; i + 1 < in_use; i++)
                    slot_of[i] = slot_of[i+1];
                slot_of[in_use-1] = slot;
                in_use--;
            end
            return v;
        endfunction

        function void note_op(t_opcode op, logic [W_VALUE-1:0] value,
                              logic [W_INDEX-1:0] index);
            t_plate_outcome o;
            int cap;
            int slot;
            bit open_new;
            o.popped = '0;
            o.status = ST_OK;
            cap = int'(capacity);
            if (cap == 0) cap = 1;
            if (cap > DEPTH) cap = DEPTH;
            case (op)
                OP_PUSH: begin
                    open_new = (in_use == 0) || (fill[slot_of[in_use-1]] >= cap);
                    if (open_new && in_use >= SLOTS) begin
                        o.status = ST_OVERFLOW;
                    end else begin
                        if (open_new) begin
                            slot = slot_of[in_use];
                            fill[slot] = 0;
                            in_use++;
                        end else begin
                            slot = slot_of[in_use-1];
                        end
                        plate_mem[slot*DEPTH + fill[slot]] = value;
                        fill[slot]++;
                    end
                end
                OP_POP: begin
                    if (in_use == 0) o.status = ST_EMPTY;
                    else o.popped = take_plate(in_use - 1);
                end
                OP_POP_AT: begin
                    if (int'(index) >= in_use) o.status = ST_BAD_INDEX;
                    else o.popped = take_plate(int'(index));
                end
                default: ;
            endcase
            o.in_use = W_INUSE'(in_use);
            expected_outcomes = {expected_outcomes, o};
        endfunction

        function void check_outcome(logic signed [W_VALUE-1:0] popped,
                                    logic [W_STATUS-1:0] status,
                                    logic [W_INUSE-1:0] in_use_seen);
            t_plate_outcome e;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result: popped %h status %0d in use %0d",
                         $time, popped, status, in_use_seen);
                mismatches++;
                return;
            end
            e = expected_outcomes.pop_front();
            if (popped !== e.popped) begin
                $display("%0t: popped_value expected %h actual %h",
                         $time, e.popped, popped);
                mismatches++;
            end
            if (status !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                mismatches++;
            end
            if (in_use_seen !== e.in_use) begin
                $display("%0t: substacks_in_use expected %0d actual %0d",
                         $time, e.in_use, in_use_seen);
                mismatches++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [W_CAP-1:0]           i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [W_OPCODE-1:0]        i_opcode = '0;
    logic signed [W_VALUE-1:0]  i_push_value = '0;
    logic [W_INDEX-1:0]         i_substack_index = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [W_VALUE-1:0]  o_popped_value;
    logic [W_STATUS-1:0]        o_status;
    logic [W_INUSE-1:0]         o_substacks_in_use;

    t_substack_tracker tracker;

    // Sender burst state and receiver stall pattern, set per phase.
    int burst_left  = 0;
    bit gap_enable  = 1'b0;
    int stall_mode  = 0;
    int stall_run   = 0;
    bit stall_level = 1'b0;

    set_of_stacks_engine_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_push_value       (i_push_value),
        .i_substack_index   (i_substack_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_popped_value     (o_popped_value),
        .o_status           (o_status),
        .o_substacks_in_use (o_substacks_in_use)
    );

    always #2 i_clk = ~i_clk;

    // Result side: check every transfer against the oldest outcome owed,
    // then pick the stall level for the next cycle.
    //   mode 0: never stall
    //   mode 1: stall on roughly one cycle in four
    //   mode 2: alternate runs of stalling and flowing of random length
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_outcome(o_popped_value, o_status, o_substacks_in_use);
        case (stall_mode)
            1: i_out_stall <= ($urandom_range(3) == 0);
            2: begin
                if (stall_run == 0) begin
                    stall_level = ~stall_level;
                    stall_run = $urandom_range(10, 1);
                end else begin
                    stall_run--;
                end
                i_out_stall <= stall_level;
            end
            default: i_out_stall <= 1'b0;
        endcase
    end

    // Present one operation and hold it until the block takes it. Between bursts,
    // when gaps are enabled, drop valid for a random number of cycles. Call at a rising edge.
    task automatic send_op(t_opcode op, logic [W_VALUE-1:0] value,
                           logic [W_INDEX-1:0] index);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            if (gap_enable) begin
                gap = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(4, 1);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_push_value     <= value;
        i_substack_index <= index;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_op(op, value, index);
    endtask

    // Wait until every outcome is in, then write the capacity register.
    task automatic set_capacity(logic [W_CAP-1:0] c);
        i_in_valid <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(posedge i_clk);
        tracker.write_capacity(c);
        i_cfg_we   <= 1'b0;
        burst_left = 0;
    endtask

    // Random operation: mostly pushes and pops whose indexes hit live
    // substacks, with some out-of-range indexes, no-ops and extreme values.
    task automatic random_op(int push_pct);
        logic [W_VALUE-1:0] v;
        logic [W_INDEX-1:0] idx;
        t_opcode op;
        int pick;
        v = $urandom;
        case ($urandom_range(11))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            default: ;
        endcase
        idx = W_INDEX'($urandom);
        if (tracker.in_use > 0 && $urandom_range(4) != 0)
            idx = W_INDEX'($urandom_range(tracker.in_use - 1, 0));
        pick = $urandom_range(99);
        if (pick < push_pct) begin
            op = OP_PUSH;
        end else begin
            case ($urandom_range(9))
                0:          op = OP_NOP;
                1, 2, 3, 4: op = OP_POP;
                default:    op = OP_POP_AT;
            endcase
        end
        send_op(op, v, idx);
    endtask

    initial begin
        logic [W_CAP-1:0] phase_cap [8];
        int               phase_push [8];
        tracker = new();
        phase_cap  = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd3, 5'd7, 5'd9};
        phase_push = '{60, 70, 55, 75, 40, 65, 50, 30};
        phase_cap[7] = W_CAP'($urandom_range(31));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty and bad-index cases at reset capacity, the no-op,
        // value extremes, a second substack opened by a full one, pop-at of
        // the oldest substack and pops until empty again.
        send_op(OP_POP,    32'h0, 4'd0);
        send_op(OP_POP_AT, 32'h0, 4'd0);
        send_op(OP_NOP,    32'hFFFF_FFFF, 4'hF);
        send_op(OP_PUSH,   32'h7FFF_FFFF, 4'h0);
        send_op(OP_PUSH,   32'h8000_0000, 4'hF);
        send_op(OP_PUSH,   32'h0000_0000, 4'h0);
        send_op(OP_PUSH,   32'hFFFF_FFFF, 4'h0);
        send_op(OP_POP_AT, 32'h0, 4'hF);
        send_op(OP_POP_AT, 32'h0, 4'd0);
        send_op(OP_POP_AT, 32'h0, 4'd0);
        send_op(OP_POP,    32'h0, 4'd0);
        send_op(OP_POP,    32'h0, 4'd0);
        send_op(OP_POP,    32'h0, 4'd0);

        // Capacity one: fill every substack, overflow once, then pop-at the
        // highest and the lowest position.
        set_capacity(5'd1);
        for (int i = 0; i <= SLOTS; i++)
            send_op(OP_PUSH, $urandom, 4'd0);
        send_op(OP_POP_AT, 32'h0, 4'hF);
        send_op(OP_POP_AT, 32'h0, 4'd0);

        // Random phases: state carries over, so lowering the capacity below
        // a fill happens between phases. Vary both idling patterns per phase.
        for (int ph = 0; ph < 8; ph++) begin
            set_capacity(phase_cap[ph]);
            gap_enable = (ph % 3 != 0);
            stall_mode = ph % 3;
            for (int n = 0; n < 130; n++)
                random_op(phase_push[ph]);
        end

        // Drain: drop valid, wait out every outcome, then a few more cycles.
        i_in_valid <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_outcomes.size() == 0)
            $display("set_of_stacks_engine_core_tb: done, clean");
        else
            $display("set_of_stacks_engine_core_tb: done, errors");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("set_of_stacks_engine_core_tb: done, errors");
        $finish;
    end

endmodule
